// File: rtl/core/mexp_pkg.sv
// Shared types, register indexes, reset values and modular add for the exponentiation core.
package mexp_pkg;

	// Width of every payload and configuration word at the ports.
	localparam int FIELD_W = 64;

	// Configuration register index.
	localparam int CFG_IDX_W = 8;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_MODULUS   = cfg_idx_t'(0);
	localparam cfg_idx_t REG_GENERATOR = cfg_idx_t'(1);

	// Register values after reset.
	localparam logic [FIELD_W-1:0] MODULUS_RST   = 64'hFFFF_FFFF_FFFF_FFC5;
	localparam logic [FIELD_W-1:0] GENERATOR_RST = 64'd2;

	// Returns (x + y) mod m for x + y < 2m, keeping the carry of the sum.
	function automatic logic [FIELD_W-1:0] add_mod(
		input logic [FIELD_W-1:0] x,
		input logic [FIELD_W-1:0] y,
		input logic [FIELD_W-1:0] m
	);
		logic [FIELD_W:0] s;
		s = {1'b0, x} + {1'b0, y};
		if (s >= {1'b0, m}) begin
			s = s - {1'b0, m};
		end
		return s[FIELD_W-1:0];
	endfunction

endpackage

// File: rtl/core/mexp_mulmod.sv
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first.
module mexp_mulmod #(
	parameter int WORD_BITS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [WORD_BITS-1:0] addend,
	input  logic [WORD_BITS-1:0] mult,
	input  logic [WORD_BITS-1:0] modulus,
	output logic                 done,
	output logic [WORD_BITS-1:0] product
);
	import mexp_pkg::*;

	localparam int CNT_W = $clog2(WORD_BITS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_BITS - 1);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [WORD_BITS-1:0] acc_q;
	logic [WORD_BITS-1:0] a_q;
	logic [WORD_BITS-1:0] mult_q;

	logic [FIELD_W-1:0]   dbl;
	logic [FIELD_W-1:0]   sum;
	logic [WORD_BITS-1:0] acc_next;

	// One step: double the accumulator, then add the addend if the multiplier bit is set.
	always_comb begin
		dbl = add_mod(FIELD_W'(acc_q), FIELD_W'(acc_q), FIELD_W'(modulus));
		sum = add_mod(dbl, FIELD_W'(a_q), FIELD_W'(modulus));
		acc_next = mult_q[WORD_BITS-1] ? sum[WORD_BITS-1:0] : dbl[WORD_BITS-1:0];
	end

	// Control and datapath registers; a new start takes precedence over a finishing run.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_LAST;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q  <= '0;
			a_q    <= addend;
			mult_q <= mult;
		end else if (busy_q) begin
			acc_q  <= acc_next;
			mult_q <= {mult_q[WORD_BITS-2:0], 1'b0};
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

// File: rtl/core/modular_exponentiation_core.sv
// Modular exponentiation core: base^exponent mod modulus by square and multiply.
//
// Input channel (in_valid / in_stall): one word carries func, base and exponent.
// With func 0 the base is the generator register, with func 1 the word's base.
// Output channel (out_valid / out_stall): one result word per input word.
// Configuration channel (cfg_valid / cfg_ready): index 0 writes the modulus,
// index 1 the generator; other indexes are ignored. cfg_ready is always high.
// Write configuration only while the core is idle.
// Each input word is worked by the single bit-serial modular multiplier that
// serves the base reduction, every squaring and every multiply in turn. A zero
// base, zero exponent or zero modulus skips the multiplier and goes straight to
// the done state. The core holds in_stall high until the result is in the output
// register, so one word is in flight at a time; the next word may be taken while
// that result still waits. A stalled receiver keeps the result in the output
// register and a finished result waits in the core behind it.
// Reset clears the channels and loads the modulus and generator reset values.
module modular_exponentiation_core #(
	parameter int WORD_BITS = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Configuration channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  mexp_pkg::cfg_idx_t             cfg_index,
	input  logic [mexp_pkg::FIELD_W-1:0]   cfg_data,
	// Input channel
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           func,
	input  logic [mexp_pkg::FIELD_W-1:0]   base,
	input  logic [mexp_pkg::FIELD_W-1:0]   exponent,
	// Output channel
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [mexp_pkg::FIELD_W-1:0]   result
);
	import mexp_pkg::*;

	localparam int CNT_W = $clog2(WORD_BITS);
	localparam logic [CNT_W-1:0]     CNT_LAST = CNT_W'(WORD_BITS - 1);
	localparam logic [WORD_BITS-1:0] ONE      = WORD_BITS'(1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RED,
		ST_SQR,
		ST_MUL,
		ST_DONE
	} state_t;

	state_t               state_q;
	logic [WORD_BITS-1:0] modulus_q;
	logic [WORD_BITS-1:0] generator_q;
	logic [WORD_BITS-1:0] base_q;
	logic [WORD_BITS-1:0] exp_q;
	logic [WORD_BITS-1:0] r_q;
	logic [CNT_W-1:0]     bit_cnt_q;
	logic                 out_valid_q;
	logic [WORD_BITS-1:0] result_q;

	logic                 in_acc;
	logic [WORD_BITS-1:0] a_sel;
	logic [WORD_BITS-1:0] e_in;
	logic                 mul_start;
	logic [WORD_BITS-1:0] mul_addend;
	logic [WORD_BITS-1:0] mul_mult;
	logic                 mul_done;
	logic [WORD_BITS-1:0] mul_product;

	// Configuration registers; writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q   <= MODULUS_RST[WORD_BITS-1:0];
			generator_q <= GENERATOR_RST[WORD_BITS-1:0];
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MODULUS:   modulus_q   <= cfg_data[WORD_BITS-1:0];
				REG_GENERATOR: generator_q <= cfg_data[WORD_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// Input selection and handshake.
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign a_sel    = func ? base[WORD_BITS-1:0] : generator_q;
	assign e_in     = exponent[WORD_BITS-1:0];

	// Operands for the shared multiplier, chosen by the sequencer state.
	always_comb begin
		mul_start  = 1'b0;
		mul_addend = mul_product;
		mul_mult   = mul_product;
		unique case (state_q)
			ST_IDLE: begin
				// Base reduction: 1 * a mod m, scanning the bits of a.
				mul_start  = in_acc && (a_sel != '0) && (e_in != '0) && (modulus_q != '0);
				mul_addend = ONE;
				mul_mult   = a_sel;
			end
			ST_RED: begin
				mul_start  = mul_done;
				mul_addend = r_q;
				mul_mult   = r_q;
			end
			ST_SQR: begin
				mul_start = mul_done && (exp_q[WORD_BITS-1] || (bit_cnt_q != '0));
				mul_mult  = exp_q[WORD_BITS-1] ? base_q : mul_product;
			end
			ST_MUL: begin
				mul_start = mul_done && (bit_cnt_q != '0);
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	mexp_mulmod #(
		.WORD_BITS (WORD_BITS)
	) u_mulmod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.addend  (mul_addend),
		.mult    (mul_mult),
		.modulus (modulus_q),
		.done    (mul_done),
		.product (mul_product)
	);

	// Sequencer: edge cases, base reduction, then a square per exponent bit and a multiply per set bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			result_q    <= '0;
			base_q      <= '0;
			exp_q       <= '0;
			r_q         <= '0;
			bit_cnt_q   <= '0;
		end else begin
			// Output register: load a finished result once it is free, else drain it.
			if (state_q == ST_DONE && (!out_valid_q || !out_stall)) begin
				result_q    <= r_q;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						exp_q     <= e_in;
						bit_cnt_q <= CNT_LAST;
						if (a_sel == '0) begin
							r_q     <= '0;
							state_q <= ST_DONE;
						end else if (e_in == '0) begin
							r_q     <= ONE;
							state_q <= ST_DONE;
						end else if (modulus_q == '0) begin
							r_q     <= '0;
							state_q <= ST_DONE;
						end else begin
							r_q     <= (modulus_q == ONE) ? '0 : ONE;
							state_q <= ST_RED;
						end
					end
				end
				ST_RED: begin
					if (mul_done) begin
						base_q  <= mul_product;
						state_q <= ST_SQR;
					end
				end
				ST_SQR: begin
					if (mul_done) begin
						r_q <= mul_product;
						if (exp_q[WORD_BITS-1]) begin
							state_q <= ST_MUL;
						end else if (bit_cnt_q == '0) begin
							state_q <= ST_DONE;
						end else begin
							exp_q     <= {exp_q[WORD_BITS-2:0], 1'b0};
							bit_cnt_q <= bit_cnt_q - 1'b1;
						end
					end
				end
				ST_MUL: begin
					if (mul_done) begin
						r_q <= mul_product;
						if (bit_cnt_q == '0) begin
							state_q <= ST_DONE;
						end else begin
							exp_q     <= {exp_q[WORD_BITS-2:0], 1'b0};
							bit_cnt_q <= bit_cnt_q - 1'b1;
							state_q   <= ST_SQR;
						end
					end
				end
				ST_DONE: begin
					// The result moves into the output register once it is free.
					if (!out_valid_q || !out_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign result    = FIELD_W'(result_q);

	// The multiplier only finishes while the sequencer is waiting on it.
	assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == ST_RED || state_q == ST_SQR || state_q == ST_MUL))
		else $error("multiplier finished outside a multiply state");

	// Operands passed on by the sequencer are already reduced.
	assert property (@(posedge clk) disable iff (!arst_n)
		(mul_start && state_q != ST_IDLE) |-> (mul_addend < modulus_q && mul_mult < modulus_q))
		else $error("unreduced operand sent to the multiplier");

	// Every product of the multiplier is fully reduced.
	assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (mul_product < modulus_q))
		else $error("multiplier product not reduced");

	// A new word is never taken while the multiplier reports done.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> !mul_done)
		else $error("input word taken during a multiplication");

endmodule

// File: sim/testbench.sv
// Self-checking testbench for the square-and-multiply modular exponentiation core.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import mexp_pkg::*;

	localparam logic                FUNC_PUBLIC = 1'b0;
	localparam logic                FUNC_SHARED = 1'b1;
	localparam logic [FIELD_W-1:0]  ALL_ONES    = '1;
	localparam cfg_idx_t            REG_UNUSED_FIRST = cfg_idx_t'(2);
	localparam cfg_idx_t            REG_UNUSED_LAST  = '1;
	localparam int                  HOLD_CYCLES = 400;

	logic                clk;
	logic                arst_n;
	logic                cfg_valid;
	logic                cfg_ready;
	cfg_idx_t            cfg_index;
	logic [FIELD_W-1:0]  cfg_data;
	logic                in_valid;
	logic                in_stall;
	logic                func;
	logic [FIELD_W-1:0]  base;
	logic [FIELD_W-1:0]  exponent;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [FIELD_W-1:0]  result;

	// Shadow copies of the core's registers, updated on each accepted write.
	logic [FIELD_W-1:0]  modulus_copy   = MODULUS_RST;
	logic [FIELD_W-1:0]  generator_copy = GENERATOR_RST;

	// Powers predicted for accepted words, oldest first.
	logic [FIELD_W-1:0]  expected_powers[$];

	int send_idle_pct = 21;
	int recv_idle_pct = 66;
	int mismatches    = 0;
	int hold_requests = 0;
	int hold_served   = 0;
	int hold_left     = 0;

	modular_exponentiation_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.base      (base),
		.exponent  (exponent),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.result    (result)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard stop in case the core stops answering.
	initial begin
		#20_000_000;
		$display("Mismatches found");
		$finish;
	end

	// (x * y) mod m through a double-width product.
	function automatic logic [FIELD_W-1:0] product_mod(
		input logic [FIELD_W-1:0] x,
		input logic [FIELD_W-1:0] y,
		input logic [FIELD_W-1:0] m
	);
		logic [2*FIELD_W-1:0] wide;
		wide = {{FIELD_W{1'b0}}, x} * {{FIELD_W{1'b0}}, y};
		wide = wide % {{FIELD_W{1'b0}}, m};
		return wide[FIELD_W-1:0];
	endfunction

	// Expected result of one word under the current register copies.
	function automatic logic [FIELD_W-1:0] predict_power(
		input logic               f,
		input logic [FIELD_W-1:0] b,
		input logic [FIELD_W-1:0] e
	);
		logic [FIELD_W-1:0] a;
		logic [FIELD_W-1:0] x;
		logic [FIELD_W-1:0] r;
		int i;
		a = (f == FUNC_SHARED) ? b : generator_copy;
		// A zero base wins over a zero exponent; a zero exponent gives an unreduced one.
		if (a == '0)
			return '0;
		if (e == '0)
			return FIELD_W'(1);
		if (modulus_copy == '0)
			return '0;
		x = a % modulus_copy;
		r = FIELD_W'(1) % modulus_copy;
		for (i = FIELD_W - 1; i >= 0; i--) begin
			r = product_mod(r, r, modulus_copy);
			if (e[i])
				r = product_mod(r, x, modulus_copy);
		end
		return r;
	endfunction

	// Receiver: random stalls, or a long hold-off when a test asks for one.
	always @(posedge clk) begin
		if (hold_requests != hold_served) begin
			hold_served <= hold_requests;
			hold_left   <= HOLD_CYCLES;
			out_stall   <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Compare every accepted result word with the oldest prediction.
	always @(posedge clk) begin
		logic [FIELD_W-1:0] want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_powers.size() == 0) begin
				$display("%0t: result word with no expectation waiting, actual %h",
					$time, result);
				mismatches++;
			end else begin
				want = expected_powers.pop_front();
				if (result !== want) begin
					$display("%0t: result mismatch, expected %h, actual %h",
						$time, want, result);
					mismatches++;
				end
			end
		end
	end

	// Write one configuration register and track it in the shadow copies.
	task automatic write_reg(input cfg_idx_t idx, input logic [FIELD_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_MODULUS)
			modulus_copy = data;
		else if (idx == REG_GENERATOR)
			generator_copy = data;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Offer one input word after a random gap; valid stays high for a following word.
	task automatic send_word(
		input logic               f,
		input logic [FIELD_W-1:0] b,
		input logic [FIELD_W-1:0] e
	);
		int gap;
		gap = 0;
		while (($urandom_range(99) < send_idle_pct) && (gap < 50))
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func     <= f;
		base     <= b;
		exponent <= e;
		do @(posedge clk); while (in_stall);
		expected_powers.push_back(predict_power(f, b, e));
	endtask

	// Stop offering words and wait until every predicted result has arrived.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_powers.size() != 0)
			@(posedge clk);
	endtask

	// Register values after reset, including bases at and above the modulus.
	task automatic test_reset_defaults();
		send_word(FUNC_PUBLIC, '0, FIELD_W'(1));
		send_word(FUNC_PUBLIC, {$urandom, $urandom}, ALL_ONES);
		send_word(FUNC_SHARED, ALL_ONES, ALL_ONES);
		send_word(FUNC_SHARED, MODULUS_RST, FIELD_W'(5));
		send_word(FUNC_SHARED, '0, '0);
		send_word(FUNC_SHARED, FIELD_W'(5), '0);
		send_word(FUNC_SHARED, MODULUS_RST - 1, FIELD_W'(2));
		drain_results();
	endtask

	// Writes to indexes beyond the register list must change nothing.
	task automatic test_unused_index();
		write_reg(REG_UNUSED_FIRST, ALL_ONES);
		write_reg(REG_UNUSED_LAST, '0);
		send_word(FUNC_PUBLIC, '0, FIELD_W'(10));
		send_word(FUNC_SHARED, FIELD_W'(3), FIELD_W'(1));
		drain_results();
	endtask

	// Largest and smallest legal modulus, the largest with a zero generator.
	task automatic test_modulus_extremes();
		write_reg(REG_MODULUS, ALL_ONES);
		write_reg(REG_GENERATOR, '0);
		send_word(FUNC_PUBLIC, ALL_ONES, '0);
		send_word(FUNC_PUBLIC, FIELD_W'(9), {$urandom, $urandom});
		send_word(FUNC_SHARED, ALL_ONES, FIELD_W'(3));
		send_word(FUNC_SHARED, ALL_ONES - 1, FIELD_W'(2));
		drain_results();
		write_reg(REG_MODULUS, FIELD_W'(2));
		write_reg(REG_GENERATOR, FIELD_W'(3));
		send_word(FUNC_PUBLIC, '0, FIELD_W'(7));
		send_word(FUNC_SHARED, FIELD_W'(2), FIELD_W'(1));
		send_word(FUNC_SHARED, ALL_ONES, ALL_ONES);
		drain_results();
	endtask

	// Modulus one and zero, where only the zero base and zero exponent rules survive.
	task automatic test_degenerate_modulus();
		write_reg(REG_MODULUS, FIELD_W'(1));
		write_reg(REG_GENERATOR, ALL_ONES);
		send_word(FUNC_PUBLIC, '0, '0);
		send_word(FUNC_PUBLIC, '0, FIELD_W'(5));
		send_word(FUNC_SHARED, '0, FIELD_W'(9));
		drain_results();
		write_reg(REG_MODULUS, '0);
		write_reg(REG_GENERATOR, '0);
		send_word(FUNC_SHARED, FIELD_W'(7), '0);
		send_word(FUNC_SHARED, FIELD_W'(7), FIELD_W'(3));
		send_word(FUNC_PUBLIC, ALL_ONES, ALL_ONES);
		drain_results();
	endtask

	// Hold the receiver off while quick words pile up and the core stalls its input.
	task automatic test_backpressure();
		write_reg(REG_MODULUS, MODULUS_RST);
		write_reg(REG_GENERATOR, FIELD_W'(5));
		hold_requests++;
		send_word(FUNC_SHARED, FIELD_W'(11), '0);
		send_word(FUNC_SHARED, '0, {$urandom, $urandom});
		send_word(FUNC_PUBLIC, FIELD_W'(1), '0);
		send_word(FUNC_SHARED, FIELD_W'(4), '0);
		send_word(FUNC_PUBLIC, '0, FIELD_W'(3));
		send_word(FUNC_SHARED, {$urandom, $urandom}, FIELD_W'(2));
		drain_results();
	endtask

	// Random words under one register setting and one idling pattern.
	task automatic test_random_traffic(
		input int                 send_pct,
		input int                 recv_pct,
		input int                 count,
		input logic [FIELD_W-1:0] m,
		input logic [FIELD_W-1:0] g
	);
		logic               f;
		logic [FIELD_W-1:0] b;
		logic [FIELD_W-1:0] e;
		int n;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		write_reg(REG_MODULUS, m);
		write_reg(REG_GENERATOR, g);
		for (n = 0; n < count; n++) begin
			f = 1'($urandom_range(1));
			// Bases lean toward the values where reduction is interesting.
			case ($urandom_range(9))
				0: b = '0;
				1: b = modulus_copy;
				2: b = modulus_copy - 1;
				3: b = ALL_ONES;
				4: b = FIELD_W'($urandom_range(1, 15));
				default: b = {$urandom, $urandom};
			endcase
			// Sparse exponents keep the run short without losing the top bits.
			case ($urandom_range(9))
				0: e = '0;
				1: e = ALL_ONES;
				2: e = FIELD_W'($urandom_range(1, 255));
				3, 4, 5: e = {$urandom, $urandom} & {$urandom, $urandom};
				default: e = {$urandom, $urandom};
			endcase
			send_word(f, b, e);
		end
		drain_results();
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_MODULUS;
		cfg_data  = '0;
		in_valid  = 1'b0;
		func      = FUNC_PUBLIC;
		base      = '0;
		exponent  = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_unused_index();
		test_modulus_extremes();
		test_degenerate_modulus();
		test_backpressure();
		test_random_traffic(21, 66, 24,
			{$urandom, $urandom} | 64'h8000_0000_0000_0001, {$urandom, $urandom});
		test_random_traffic(66, 21, 24,
			FIELD_W'($urandom_range(2, 5000)), {$urandom, $urandom});
		test_random_traffic(0, 0, 24,
			{$urandom, $urandom}, FIELD_W'($urandom_range(0, 7)));

		// Let any stray result word show up before the verdict.
		drain_results();
		repeat (200) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
